// ===== rtl/kad_pkg.sv =====
package kad_pkg;

   // Command codes carried in req_tuser
   localparam logic [1:0] CMD_VOFS   = 2'd0;
   localparam logic [1:0] CMD_TRIG   = 2'd1;
   localparam logic [1:0] CMD_TIME   = 2'd2;
   localparam logic [1:0] CMD_SCREEN = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_HOLD_MS      = 2'd0;
   localparam logic [1:0] CSR_OFFSET_ZERO  = 2'd1;
   localparam logic [1:0] CSR_TRIGGER_ZERO = 2'd2;

   localparam logic [15:0] HOLD_MS_RST      = 16'd500;
   localparam logic [15:0] OFFSET_ZERO_RST  = 16'd500;
   localparam logic [15:0] TRIGGER_ZERO_RST = 16'd500;

   // Acceleration thresholds in ms
   localparam logic [31:0] ACCEL_T1 = 32'd75;
   localparam logic [31:0] ACCEL_T2 = 32'd50;
   localparam logic [31:0] ACCEL_T3 = 32'd25;

   localparam int KNOB_SLOTS_DEF = 4;

   localparam int HOLD_SLOTS = 4;
   localparam logic [1:0] HOLD_TIME_IDX = 2'd3;
   localparam logic [1:0] HOLD_LAST_CH  = 2'd2;

   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int VAL_W      = 16;
   localparam int REQ_DATA_W = 64;
   localparam int SCALED_W   = 11;

   // Outcome of one event: result and hold-table update
   typedef struct packed {
      logic              apply;
      logic [VAL_W-1:0]  new_value;
      logic              start_we;
      logic              vld_we;
      logic              vld_val;
   } kad_upd_type;

endpackage

// ===== rtl/knob_accel_zero_detent.sv =====
// Knob acceleration with zero detent.
// req channel: one knob event per transaction. req_tuser carries the command
// (vertical offset, trigger level, time offset, screen shift); req_tdata packs
// knob slot, channel, signed step, current setting and the ms timestamp.
// rsp channel: one result per event. rsp_tuser is the apply flag, rsp_tdata
// the new setting (or relative shift for screen shift), zero when refused.
// csr channel: writes hold_ms, offset_zero and trigger_zero; always ready.
// Write it only while no event is in flight.
// The result passes through the compute stage into the output register. One
// event per cycle is sustained while the receiver does not stall: the
// last-event-time and hold-start memories are read at accept and written
// back when the compute stage advances, and a read that meets a write to the
// same entry on the same edge takes the forwarded value.
// Reset clears all last-event times to zero, drops every detent hold and
// loads the registers with 500. When the receiver stalls, the result waits
// in the output register, the event behind it waits in the compute stage,
// and req_tready drops only once both are full.
module knob_accel_zero_detent #(
   parameter int KNOB_SLOTS = kad_pkg::KNOB_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tuser: command[1:0]
   input  logic [kad_pkg::CMD_W-1:0]         req_tuser,
   // tdata: knob[1:0], channel[3:2], step[11:4], current_value[27:12],
   //        now_ms[59:28], zero fill[63:60]
   input  logic [kad_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tuser: apply[0]
   output logic                              rsp_tuser,
   // tdata: new_value[15:0]
   output logic [kad_pkg::VAL_W-1:0]         rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kad_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                       csr_wdata
);
   import kad_pkg::*;

   localparam int SLOT_W = (KNOB_SLOTS > 1) ? $clog2(KNOB_SLOTS) : 1;

   // Configuration registers
   logic [15:0] hold_ms_ff;
   logic [15:0] offset_zero_ff;
   logic [15:0] trigger_zero_ff;

   // Request field unpacking
   logic [1:0]         in_knob;
   logic [1:0]         in_channel;
   logic signed [7:0]  in_step;
   logic signed [15:0] in_cur;
   logic [31:0]        in_now;

   // Compute stage
   logic                s1_valid_ff;
   logic [CMD_W-1:0]    s1_cmd_ff;
   logic signed [7:0]   s1_step_ff;
   logic signed [15:0]  s1_cur_ff;
   logic [31:0]         s1_now_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic [1:0]          s1_hidx_ff;
   logic [31:0]         lt_rd_ff;
   logic [31:0]         hs_rd_ff;

   // State memories and their valid bits
   logic [31:0]           lt_mem [KNOB_SLOTS];
   logic [KNOB_SLOTS-1:0] knob_vld_ff;
   logic [31:0]           hs_mem [HOLD_SLOTS];
   logic [HOLD_SLOTS-1:0] hold_vld_ff;

   // Output register
   logic             rsp_valid_ff;
   logic             rsp_apply_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   logic              req_acc;
   logic              s1_adv;
   logic [4:0]        slot_wide;
   logic [SLOT_W-1:0] in_slot;
   logic [1:0]        in_hidx;
   kad_upd_type       upd;

   assign in_knob    = req_tdata[1:0];
   assign in_channel = req_tdata[3:2];
   assign in_step    = req_tdata[11:4];
   assign in_cur     = req_tdata[27:12];
   assign in_now     = req_tdata[59:28];

   // Handshake: advance the compute stage when the output register frees up
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_apply_ff;
   assign rsp_tdata  = rsp_value_ff;

   // Knob slot: wrap the knob number into the slot range
   always_comb begin
      slot_wide = {3'b000, in_knob};
      for (int i = 0; i < 3; i++) begin
         if (slot_wide >= 5'(KNOB_SLOTS)) begin
            slot_wide = slot_wide - 5'(KNOB_SLOTS);
         end
      end
   end
   assign in_slot = slot_wide[SLOT_W-1:0];

   // Hold entry: channels share with trigger, time offset has its own
   always_comb begin
      case (req_tuser)
         CMD_TIME, CMD_SCREEN: begin
            in_hidx = HOLD_TIME_IDX;
         end
         default: begin
            in_hidx = (in_channel > HOLD_LAST_CH) ? HOLD_LAST_CH : in_channel;
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ms_ff      <= HOLD_MS_RST;
         offset_zero_ff  <= OFFSET_ZERO_RST;
         trigger_zero_ff <= TRIGGER_ZERO_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HOLD_MS:      hold_ms_ff      <= csr_wdata;
            CSR_OFFSET_ZERO:  offset_zero_ff  <= csr_wdata;
            CSR_TRIGGER_ZERO: trigger_zero_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Compute stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Capture payload; read both memories, forward a same-edge write-back
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff  <= req_tuser;
         s1_step_ff <= in_step;
         s1_cur_ff  <= in_cur;
         s1_now_ff  <= in_now;
         s1_slot_ff <= in_slot;
         s1_hidx_ff <= in_hidx;
         if (s1_adv && (s1_slot_ff == in_slot)) begin
            lt_rd_ff <= s1_now_ff;
         end else if (knob_vld_ff[in_slot]) begin
            lt_rd_ff <= lt_mem[in_slot];
         end else begin
            lt_rd_ff <= '0;
         end
         if (s1_adv && upd.start_we && (s1_hidx_ff == in_hidx)) begin
            hs_rd_ff <= s1_now_ff;
         end else begin
            hs_rd_ff <= hs_mem[in_hidx];
         end
      end
   end

   // Memory write-back
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         lt_mem[s1_slot_ff] <= s1_now_ff;
         if (upd.start_we) begin
            hs_mem[s1_hidx_ff] <= s1_now_ff;
         end
      end
   end

   // Valid bits: an unwritten knob slot reads as zero, a cleared hold is off
   always_ff @(posedge clock) begin
      if (reset) begin
         knob_vld_ff <= '0;
         hold_vld_ff <= '0;
      end else if (s1_adv) begin
         knob_vld_ff[s1_slot_ff] <= 1'b1;
         if (upd.vld_we) begin
            hold_vld_ff[s1_hidx_ff] <= upd.vld_val;
         end
      end
   end

   kad_calc u_calc (
      .cmd          (s1_cmd_ff),
      .step         (s1_step_ff),
      .cur          (s1_cur_ff),
      .now_ms       (s1_now_ff),
      .last_time    (lt_rd_ff),
      .hold_start   (hs_rd_ff),
      .hold_valid   (hold_vld_ff[s1_hidx_ff]),
      .hold_ms      (hold_ms_ff),
      .offset_zero  (offset_zero_ff),
      .trigger_zero (trigger_zero_ff),
      .upd          (upd)
   );

   // Output register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_apply_ff <= upd.apply;
         rsp_value_ff <= upd.new_value;
      end
   end

endmodule

// ===== rtl/kad_calc.sv =====
module kad_calc (
   input  logic [kad_pkg::CMD_W-1:0]  cmd,
   input  logic signed [7:0]          step,
   input  logic signed [15:0]         cur,
   input  logic [31:0]                now_ms,
   input  logic [31:0]                last_time,
   input  logic [31:0]                hold_start,
   input  logic                       hold_valid,
   input  logic [15:0]                hold_ms,
   input  logic [15:0]                offset_zero,
   input  logic [15:0]                trigger_zero,
   output kad_pkg::kad_upd_type       upd
);
   import kad_pkg::*;

   logic [31:0]                 delta;
   logic [31:0]                 hold_age;
   logic signed [SCALED_W-1:0]  step_x;
   logic signed [SCALED_W-1:0]  scaled;
   logic signed [SCALED_W-1:0]  scaled_nz;
   logic [15:0]                 zero16;
   logic signed [17:0]          zero_x;
   logic signed [17:0]          cur_x;
   logic signed [17:0]          sum_x;
   logic                        cross_lin;
   logic signed [15:0]          wsum;
   logic                        cross_time;
   logic [15:0]                 result;
   logic                        at_zero;

   assign delta    = now_ms - last_time;
   assign hold_age = now_ms - hold_start;
   assign step_x   = {{(SCALED_W-8){step[7]}}, step};

   // Acceleration 1..4 from time since this knob's last event
   always_comb begin
      if (delta > ACCEL_T1) begin
         scaled = step_x;
      end else if (delta > ACCEL_T2) begin
         scaled = step_x <<< 1;
      end else if (delta > ACCEL_T3) begin
         scaled = step_x + (step_x <<< 1);
      end else begin
         scaled = step_x <<< 2;
      end
   end

   assign scaled_nz = (scaled == '0) ? SCALED_W'(1) : scaled;

   // Vertical offset and trigger level: crossing tested on the unwrapped sum
   assign zero16    = (cmd == CMD_VOFS) ? offset_zero : trigger_zero;
   assign zero_x    = $signed({2'b00, zero16});
   assign cur_x     = {{2{cur[15]}}, cur};
   assign sum_x     = cur_x + {{(18-SCALED_W){scaled[SCALED_W-1]}}, scaled};
   assign cross_lin = ((cur_x > zero_x) && (sum_x < zero_x)) ||
                      ((cur_x < zero_x) && (sum_x > zero_x));

   // Time offset: wrap first, then test against zero
   assign wsum       = cur + {{(16-SCALED_W){scaled_nz[SCALED_W-1]}}, scaled_nz};
   assign cross_time = ((cur > 16'sd0) && (wsum < 16'sd0)) ||
                       ((cur < 16'sd0) && (wsum > 16'sd0));

   always_comb begin
      result  = '0;
      at_zero = 1'b0;
      case (cmd)
         CMD_VOFS, CMD_TRIG: begin
            result  = cross_lin ? zero16 : sum_x[15:0];
            at_zero = (result == zero16);
         end
         CMD_TIME: begin
            result  = cross_time ? 16'd0 : wsum;
            at_zero = (result == 16'd0);
         end
         CMD_SCREEN: begin
            result  = {{(16-SCALED_W){scaled_nz[SCALED_W-1]}}, scaled_nz};
            at_zero = 1'b0;
         end
         default: begin
            result  = '0;
            at_zero = 1'b0;
         end
      endcase
   end

   // Detent hold check
   always_comb begin
      upd.apply    = 1'b1;
      upd.start_we = 1'b0;
      upd.vld_we   = 1'b0;
      upd.vld_val  = 1'b0;
      if (cmd != CMD_SCREEN) begin
         if (at_zero) begin
            upd.start_we = 1'b1;
            upd.vld_we   = 1'b1;
            upd.vld_val  = 1'b1;
         end else if (hold_valid) begin
            if (hold_age > {16'd0, hold_ms}) begin
               upd.vld_we  = 1'b1;
               upd.vld_val = 1'b0;
            end else begin
               upd.apply = 1'b0;
            end
         end
      end
      upd.new_value = upd.apply ? result : '0;
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kad_pkg::*;

   // Run bounds: hard cycle ceiling, drain wait per phase, quiet cycles after a drain
   localparam int RUN_LIMIT   = 200000;
   localparam int DRAIN_LIMIT = 2000;
   localparam int SETTLE      = 8;

   // One expected transaction on the rsp side
   typedef struct packed {
      logic        apply;
      logic [15:0] value;
   } knob_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   // Predicted results, oldest first
   knob_result_type results_due[$];

   // Predictor copy of block state and registers
   logic [31:0] knob_last_ms [KNOB_SLOTS_DEF];
   logic [31:0] detent_start [HOLD_SLOTS];
   logic        detent_live  [HOLD_SLOTS];
   logic [15:0] cfg_hold_ms;
   logic [15:0] cfg_offset_zero;
   logic [15:0] cfg_trigger_zero;

   // Stimulus timestamp, advanced by the generators
   logic [31:0] stim_ms = '0;

   // Idle controls for the sender and the receiver
   logic send_idle     = 1'b1;
   logic rx_idle       = 1'b1;
   int   rx_hold_cycles = 0;

   int events_sent  = 0;
   int results_seen = 0;
   int refused_seen = 0;
   int failures     = 0;
   int csr_writes   = 0;
   int phases_run   = 0;
   int cycle_count  = 0;

   always #4 clock = ~clock;

   knob_accel_zero_detent u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Map the time since a knob's last event to its acceleration factor
   function automatic int accel_factor(input logic [31:0] gap_ms);
      if (gap_ms > ACCEL_T1) return 1;
      if (gap_ms > ACCEL_T2) return 2;
      if (gap_ms > ACCEL_T3) return 3;
      return 4;
   endfunction

   // Arm, test or drop one detent hold; returns whether the change goes through
   function automatic logic detent_gate(input logic [1:0] idx, input logic at_zero,
                                        input logic [31:0] now);
      if (at_zero) begin
         detent_start[idx] = now;
         detent_live[idx]  = 1'b1;
         return 1'b1;
      end
      if (!detent_live[idx]) return 1'b1;
      if (now - detent_start[idx] > {16'd0, cfg_hold_ms}) begin
         detent_live[idx] = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Compute the result of one knob event and advance the predictor state
   function automatic knob_result_type predict_knob_result(
         input logic [1:0] cmd, input logic [1:0] knob, input logic [1:0] chan,
         input logic signed [7:0] step, input logic signed [15:0] cur,
         input logic [31:0] now);
      knob_result_type r;
      int scaled;
      int zero;
      int sum;
      int cur_i;
      int wrapped_i;
      int slot;
      logic signed [15:0] wrap16;
      logic [15:0] res;
      logic ok;
      slot = int'(knob) % KNOB_SLOTS_DEF;
      scaled = int'(step) * accel_factor(now - knob_last_ms[slot]);
      knob_last_ms[slot] = now;
      cur_i = int'(cur);
      ok = 1'b1;
      if (cmd == CMD_VOFS || cmd == CMD_TRIG) begin
         zero = (cmd == CMD_VOFS) ? int'(cfg_offset_zero) : int'(cfg_trigger_zero);
         // crossing is judged on the full sum, wrap comes afterwards
         sum = cur_i + scaled;
         if ((cur_i > zero && sum < zero) || (cur_i < zero && sum > zero)) sum = zero;
         res = sum[15:0];
         ok = detent_gate((chan > HOLD_LAST_CH) ? HOLD_LAST_CH : chan,
                          res == zero[15:0], now);
      end else begin
         if (scaled == 0) scaled = 1;
         if (cmd == CMD_TIME) begin
            // time offset wraps first, then tests against zero
            sum = cur_i + scaled;
            wrap16 = sum[15:0];
            wrapped_i = int'(wrap16);
            if ((cur_i > 0 && wrapped_i < 0) || (cur_i < 0 && wrapped_i > 0)) wrapped_i = 0;
            res = wrapped_i[15:0];
            ok = detent_gate(HOLD_TIME_IDX, wrapped_i == 0, now);
         end else begin
            res = scaled[15:0];
         end
      end
      r.apply = ok;
      r.value = ok ? res : 16'd0;
      return r;
   endfunction

   // Offer one knob event, hold it until accepted, then queue its prediction.
   // Entered and left at a falling edge.
   task automatic send_event(input logic [1:0] cmd, input logic [1:0] knob,
                             input logic [1:0] chan, input logic signed [7:0] step,
                             input logic signed [15:0] cur, input logic [31:0] now);
      int gap;
      if (send_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, now, cur, step, chan, knob};
      do @(posedge clock); while (!req_tready);
      results_due.push_back(predict_knob_result(cmd, knob, chan, step, cur, now));
      events_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted result up to the drain limit, then let the pipeline settle
   task automatic wait_results_done();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HOLD_MS:      cfg_hold_ms      = data;
         CSR_OFFSET_ZERO:  cfg_offset_zero  = data;
         CSR_TRIGGER_ZERO: cfg_trigger_zero = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Reprogram all three registers once the block has gone idle
   task automatic set_config(input logic [15:0] hold, input logic [15:0] ofs_zero,
                             input logic [15:0] trig_zero);
      wait_results_done();
      write_csr(CSR_HOLD_MS, hold);
      write_csr(CSR_OFFSET_ZERO, ofs_zero);
      write_csr(CSR_TRIGGER_ZERO, trig_zero);
   endtask

   function automatic logic [15:0] zero_point(input logic [1:0] cmd);
      if (cmd == CMD_VOFS) return cfg_offset_zero;
      if (cmd == CMD_TRIG) return cfg_trigger_zero;
      return 16'd0;
   endfunction

   // One loosely shaped event: values cluster around zero points and wrap edges,
   // timestamps mostly advance, sometimes jump to an arbitrary value
   task automatic random_event();
      logic [1:0] cmd;
      logic [1:0] knob;
      logic [1:0] chan;
      int step;
      int cur;
      int pick;
      cmd  = 2'($urandom_range(0, 3));
      knob = 2'($urandom_range(0, 3));
      chan = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 6) step = int'($urandom_range(0, 16)) - 8;
      else step = int'($urandom_range(0, 255)) - 128;
      pick = $urandom_range(0, 19);
      if (pick < 10)      stim_ms = stim_ms + $urandom_range(0, 100);
      else if (pick < 15) stim_ms = stim_ms + cfg_hold_ms + $urandom_range(0, 4) - 32'd2;
      else if (pick < 18) stim_ms = stim_ms + $urandom_range(0, 2000);
      else                stim_ms = $urandom();
      pick = $urandom_range(0, 9);
      if (pick < 6 && cmd != CMD_SCREEN)
         cur = int'(signed'(zero_point(cmd))) + int'($urandom_range(0, 40)) - 20;
      else if (pick == 6) cur = 32767 - int'($urandom_range(0, 10));
      else if (pick == 7) cur = -32768 + int'($urandom_range(0, 10));
      else cur = $urandom_range(0, 65535);
      send_event(cmd, knob, chan, 8'(step), 16'(cur), stim_ms);
   endtask

   // Land exactly on a zero point, then poke the same hold before, at and past
   // its expiry
   task automatic detent_sequence();
      logic [1:0] cmd;
      logic [1:0] knob;
      logic [1:0] chan;
      logic [1:0] next_cmd;
      logic [1:0] next_chan;
      logic [15:0] zp;
      logic [31:0] t0;
      logic [31:0] offs;
      int step;
      int scaled;
      int cur;
      int n;
      cmd  = 2'($urandom_range(0, 2));
      knob = 2'($urandom_range(0, 3));
      chan = 2'($urandom_range(0, 3));
      zp   = zero_point(cmd);
      step = int'($urandom_range(1, 16)) * ($urandom_range(0, 1) ? 1 : -1);
      stim_ms = stim_ms + $urandom_range(0, 120);
      // pick the start value so that the scaled step ends on the zero point
      scaled = step * accel_factor(stim_ms - knob_last_ms[knob]);
      cur = int'(signed'(zp)) - scaled;
      send_event(cmd, knob, chan, 8'(step), 16'(cur), stim_ms);
      t0 = stim_ms;
      n = $urandom_range(2, 6);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: offs = $urandom_range(0, cfg_hold_ms);
            1: offs = {16'd0, cfg_hold_ms};
            2: offs = {16'd0, cfg_hold_ms} + 32'd1;
            default: offs = {16'd0, cfg_hold_ms} + $urandom_range(0, 100);
         endcase
         stim_ms = t0 + offs;
         next_cmd  = (cmd == CMD_TIME) ? CMD_TIME : ($urandom_range(0, 1) ? CMD_TRIG : CMD_VOFS);
         next_chan = (chan >= HOLD_LAST_CH) ? 2'($urandom_range(2, 3)) : chan;
         cur = int'(signed'(zero_point(next_cmd))) + int'($urandom_range(0, 100)) - 50;
         send_event(next_cmd, 2'($urandom_range(0, 3)), next_chan,
                    8'(int'($urandom_range(0, 16)) - 8), 16'(cur), stim_ms);
      end
   endtask

   // Hold arming at timestamp zero, sharing between vertical and trigger,
   // channel three folding onto channel two, and the exact hold boundary
   task automatic test_zero_detent();
      send_event(CMD_VOFS, 2'd0, 2'd0, -1, 503, 32'd0);
      send_event(CMD_VOFS, 2'd1, 2'd0,  1, 500, 32'd10);
      send_event(CMD_TRIG, 2'd1, 2'd0,  1, 700, 32'd20);
      send_event(CMD_TRIG, 2'd2, 2'd1,  1, 700, 32'd30);
      send_event(CMD_TRIG, 2'd2, 2'd3,  2, 498, 32'd40);
      send_event(CMD_VOFS, 2'd2, 2'd2,  1, 100, 32'd50);
      send_event(CMD_VOFS, 2'd0, 2'd0,  1, 600, 32'd500);
      send_event(CMD_VOFS, 2'd0, 2'd0,  1, 600, 32'd501);
      send_event(CMD_VOFS, 2'd0, 2'd0,  1, 600, 32'd502);
   endtask

   // Acceleration band edges, forced unit step, 16-bit wrap of values and
   // the timestamp wrap
   task automatic test_accel_and_wrap();
      int gaps [6] = '{76, 75, 51, 50, 26, 25};
      logic [31:0] t;
      t = 32'd1000;
      send_event(CMD_SCREEN, 2'd3, 2'd0, 0, 0, t);
      foreach (gaps[i]) begin
         t = t + gaps[i];
         send_event(CMD_SCREEN, 2'd3, 2'd1, (i % 2 == 0) ? -8'sd128 : 8'sd127, 0, t);
      end
      send_event(CMD_TIME, 2'd0, 2'd0, 0, 0, 32'd2000);
      send_event(CMD_TIME, 2'd0, 2'd0, 1, 32767, 32'd3000);
      send_event(CMD_TIME, 2'd1, 2'd0, 5, 100, 32'd3100);
      send_event(CMD_VOFS, 2'd1, 2'd1, 127, 32767, 32'd3110);
      send_event(CMD_TRIG, 2'd1, 2'd1, -128, -32768, 32'd3120);
      send_event(CMD_SCREEN, 2'd2, 2'd0, 1, 0, 32'hFFFF_FFF0);
      send_event(CMD_SCREEN, 2'd2, 2'd0, 1, 0, 32'h0000_0010);
      stim_ms = 32'h0000_0010;
   endtask

   // One register setting with a mix of hold sequences and loose events
   task automatic test_random_phase(input logic [15:0] hold, input logic [15:0] ofs_zero,
                                    input logic [15:0] trig_zero, input int count);
      int target;
      set_config(hold, ofs_zero, trig_zero);
      phases_run++;
      target = events_sent + count;
      while (events_sent < target) begin
         if ($urandom_range(0, 2) == 0) detent_sequence();
         else random_event();
      end
   endtask

   // Stall the receiver long enough to fill the block while the sender keeps
   // offering, then pause the sender until everything has come back
   task automatic test_backpressure();
      send_idle = 1'b0;
      rx_hold_cycles = 80;
      repeat (30) random_event();
      wait_results_done();
      send_idle = 1'b1;
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_steady_stream();
      set_config(16'd100, 16'd250, 16'd750);
      phases_run++;
      send_idle = 1'b0;
      rx_idle   = 1'b0;
      repeat (50) begin
         if ($urandom_range(0, 3) == 0) detent_sequence();
         else random_event();
      end
   endtask

   // Receiver: random stall bursts, or a long counted hold-off when asked
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rx_hold_cycles--;
         end else if (rx_idle && stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each rsp transaction with the oldest prediction
   always @(posedge clock) begin
      knob_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (!rsp_tuser) refused_seen++;
         if (results_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: apply=%0b value=%h", rsp_tuser, rsp_tdata);
         end else begin
            want = results_due.pop_front();
            if (want.apply !== rsp_tuser || want.value !== rsp_tdata) begin
               failures++;
               if (failures <= 10)
                  $display("mismatch on result %0d: expected apply=%0b value=%h, got apply=%0b value=%h",
                           results_seen, want.apply, want.value, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   // Watchdog: count cycles and abort a hung run
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: errors");
      $finish;
   end

   initial begin
      // predictor mirrors the reset state of the block
      foreach (knob_last_ms[i]) knob_last_ms[i] = '0;
      foreach (detent_start[i]) begin
         detent_start[i] = '0;
         detent_live[i]  = 1'b0;
      end
      cfg_hold_ms      = HOLD_MS_RST;
      cfg_offset_zero  = OFFSET_ZERO_RST;
      cfg_trigger_zero = TRIGGER_ZERO_RST;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_detent();
      test_accel_and_wrap();
      test_random_phase(16'd500, 16'd500, 16'd500, 115);
      test_random_phase(16'd0, 16'd0, 16'hFFFF, 115);
      test_random_phase(16'hFFFF, 16'h8000, 16'd1, 115);
      test_random_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 115);
      test_random_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 115);
      test_random_phase(16'd20, 16'd32767, 16'd0, 115);
      test_backpressure();
      test_steady_stream();

      // drain the tail, then count anything that never showed up
      wait_results_done();
      if (results_due.size() != 0) begin
         failures += results_due.size();
         $display("%0d predicted results never arrived", results_due.size());
      end

      $display("summary: %0d knob events over %0d register settings, %0d csr writes",
               events_sent, phases_run, csr_writes);
      $display("summary: %0d results checked, %0d refused by a hold, %0d cycles",
               results_seen, refused_seen, cycle_count);
      if (failures == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
